>>> rtl/ecm_pkg.sv
`default_nettype none
package ecm_pkg;

  localparam int MAP_ENTRIES_DEF = 65536;
  localparam int EDGE_W          = 32;
  localparam int VAL_W           = 8;
  localparam int COUNT_W         = 17;
  localparam int TOTAL_W         = 32;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EDGE_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RARE_THRESHOLD  = 1'b1;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_CAS    = 2'd1,
    REQ_MERGE  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_REDUCE = 2'd1,
    ST_READ   = 2'd2,
    ST_MODIFY = 2'd3
  } state_t;

endpackage
`default_nettype wire

>>> rtl/ecm_store.sv
`default_nettype none
module ecm_store #(
  parameter int MAP_ENTRIES = ecm_pkg::MAP_ENTRIES_DEF,
  localparam int ADDR_W = $clog2(MAP_ENTRIES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output logic      [ecm_pkg::VAL_W-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic [ecm_pkg::VAL_W-1:0] wr_data,
  output logic                          clearing
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_ENTRIES - 1);

  logic [ecm_pkg::VAL_W-1:0] mem [MAP_ENTRIES];
  logic [ADDR_W-1:0]         clr_addr;
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [ecm_pkg::VAL_W-1:0] wdata;

  // sweep zeros through every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  assign we    = clearing | wr_en;
  assign waddr = clearing ? clr_addr : wr_addr;
  assign wdata = clearing ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/ecm_index.sv
`default_nettype none
module ecm_index #(
  parameter int MAP_ENTRIES = ecm_pkg::MAP_ENTRIES_DEF,
  localparam int ADDR_W = $clog2(MAP_ENTRIES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ecm_pkg::EDGE_W-1:0] raw,
  output logic                            busy,
  output logic      [ADDR_W-1:0]          slot
);

  localparam int EW       = ecm_pkg::EDGE_W;
  localparam bit IS_POW2  = (MAP_ENTRIES == (1 << ADDR_W));
  localparam logic [63:0] MAP_W64 = 64'(MAP_ENTRIES);
  // round-up reciprocal: 2^32 * (2^ADDR_W - MAP_ENTRIES) / MAP_ENTRIES + 1
  localparam logic [63:0] MAGIC_W64 =
    ((((64'd1 << ADDR_W) - MAP_W64) << EW) / MAP_W64) + 64'd1;
  localparam logic [EW-1:0] MAGIC   = EW'(MAGIC_W64);
  localparam logic [EW-1:0] MAP_LIM = EW'(MAP_ENTRIES);

  logic [2:0]      step;
  logic [EW-1:0]   num;
  logic [EW-1:0]   hi;
  logic [EW-1:0]   quo;
  logic [EW-1:0]   rem;
  logic [2*EW-1:0] prod;

  assign prod = (2*EW)'(num) * (2*EW)'(MAGIC);
  assign busy = |step;

  // advance three steps: reciprocal product, quotient, remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= IS_POW2 ? 3'b000 : 3'b001;
    end else begin
      step <= {step[1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= raw;
    end
    if (step[0]) begin
      hi <= prod[2*EW-1:EW];
    end
    if (step[1]) begin
      quo <= (hi + ((num - hi) >> 1)) >> (ADDR_W - 1);
    end
    if (step[2]) begin
      rem <= num - quo * MAP_LIM;
    end
  end

  assign slot = IS_POW2 ? num[ADDR_W-1:0] : rem[ADDR_W-1:0];

endmodule
`default_nettype wire

>>> rtl/edge_coverage_map_tracker_core.sv
`default_nettype none
// Edge coverage map: one byte per edge in a single-port-style synchronous
// memory, zeroed by a sweep after reset, during which no request is taken
// (configuration writes still land). One request is worked at a time:
// accept, memory read, then update and write back with the result loaded
// into the output register; a request whose index is rejected skips the
// memory read. A wrapped record index costs no extra time for a
// power-of-two map; for other sizes the request waits while the modulo unit
// runs three pipelined steps of a reciprocal-multiply reduction. The next
// request is taken while a finished result still waits on out_ready; a
// result is held in the update step only while the output register is
// still full.
module edge_coverage_map_tracker_core #(
  parameter int MAP_ENTRIES = ecm_pkg::MAP_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [ecm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ecm_pkg::VAL_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [ecm_pkg::EDGE_W-1:0]    edge_id,
  input  wire logic [ecm_pkg::VAL_W-1:0]     expected_value,
  input  wire logic [ecm_pkg::VAL_W-1:0]     new_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               success,
  output logic                               out_of_range,
  output logic      [ecm_pkg::VAL_W-1:0]     old_value,
  output logic                               is_rare,
  output logic      [ecm_pkg::COUNT_W-1:0]   covered_slots,
  output logic      [ecm_pkg::TOTAL_W-1:0]   new_edge_total
);

  localparam int ADDR_W = $clog2(MAP_ENTRIES);
  localparam bit IS_POW2 = (MAP_ENTRIES == (1 << ADDR_W));
  localparam logic [ecm_pkg::EDGE_W-1:0] MAP_LIMIT = ecm_pkg::EDGE_W'(MAP_ENTRIES);

  ecm_pkg::state_t state, state_next;

  logic wrap_edge_index;
  logic [ecm_pkg::VAL_W-1:0] rare_threshold;

  ecm_pkg::req_t             kind;
  logic [ecm_pkg::EDGE_W-1:0] edge_q;
  logic [ecm_pkg::VAL_W-1:0]  expect_q;
  logic [ecm_pkg::VAL_W-1:0]  fresh_q;
  logic                       reject_q;
  logic                       wrapped_q;

  logic [ecm_pkg::COUNT_W-1:0] nonzero_count, nonzero_count_next;
  logic [ecm_pkg::TOTAL_W-1:0] new_edge_count, new_edge_count_next;

  logic                      accept, commit, clearing, idx_busy, rd_en;
  logic                      reject_in, wrap_in, reduce_in;
  logic [ADDR_W-1:0]         idx_slot, slot;
  logic [ecm_pkg::VAL_W-1:0] rd_data, prior_val, wr_val;
  logic                      do_write, ok, rare;

  ecm_pkg::req_t kind_in;
  assign kind_in = ecm_pkg::req_t'(req_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_edge_index <= 1'b1;
      rare_threshold  <= ecm_pkg::VAL_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        ecm_pkg::CFG_WRAP_EDGE_INDEX: wrap_edge_index <= cfg_data[0];
        ecm_pkg::CFG_RARE_THRESHOLD:  rare_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept    = in_valid && in_ready;
  assign wrap_in   = (kind_in == ecm_pkg::REQ_RECORD) && wrap_edge_index;
  assign reject_in = !wrap_in && (edge_id >= MAP_LIMIT);
  assign reduce_in = wrap_in && !IS_POW2;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= kind_in;
      edge_q    <= edge_id;
      expect_q  <= expected_value;
      fresh_q   <= new_value;
      reject_q  <= reject_in;
      wrapped_q <= wrap_in;
    end
  end

  ecm_index #(.MAP_ENTRIES(MAP_ENTRIES)) u_index (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .raw  (edge_id),
    .busy (idx_busy),
    .slot (idx_slot)
  );

  assign slot = wrapped_q ? idx_slot : edge_q[ADDR_W-1:0];

  ecm_store #(.MAP_ENTRIES(MAP_ENTRIES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data),
    .wr_en   (commit && do_write),
    .wr_addr (slot),
    .wr_data (wr_val),
    .clearing(clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    case (state)
      ecm_pkg::ST_IDLE: begin
        in_ready = !clearing;
        if (in_valid && !clearing) begin
          if (reject_in) begin
            state_next = ecm_pkg::ST_MODIFY;
          end else if (reduce_in) begin
            state_next = ecm_pkg::ST_REDUCE;
          end else begin
            state_next = ecm_pkg::ST_READ;
          end
        end
      end
      ecm_pkg::ST_REDUCE: begin
        if (!idx_busy) begin
          state_next = ecm_pkg::ST_READ;
        end
      end
      ecm_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = ecm_pkg::ST_MODIFY;
      end
      ecm_pkg::ST_MODIFY: begin
        // hold until the output register can take the result
        commit = !out_valid || out_ready;
        if (commit) begin
          state_next = ecm_pkg::ST_IDLE;
        end
      end
      default: state_next = ecm_pkg::ST_IDLE;
    endcase
  end

  // update step: decide the write and the count changes
  always_comb begin
    prior_val = reject_q ? '0 : rd_data;
    rare      = (prior_val != '0) && (prior_val <= rare_threshold);
    do_write  = 1'b0;
    wr_val    = prior_val;
    new_edge_count_next = new_edge_count;
    if (!reject_q) begin
      case (kind)
        ecm_pkg::REQ_RECORD: begin
          if (prior_val == '0) begin
            do_write = 1'b1;
            wr_val   = ecm_pkg::VAL_W'(1);
            new_edge_count_next = new_edge_count + ecm_pkg::TOTAL_W'(1);
          end
        end
        ecm_pkg::REQ_CAS: begin
          if (prior_val == expect_q) begin
            do_write = 1'b1;
            wr_val   = fresh_q;
          end
        end
        ecm_pkg::REQ_MERGE: begin
          if (fresh_q != '0 && prior_val == '0) begin
            do_write = 1'b1;
            wr_val   = fresh_q;
          end
        end
        default: ;
      endcase
    end
    ok = do_write;
    nonzero_count_next = nonzero_count;
    if (do_write && prior_val == '0 && wr_val != '0) begin
      nonzero_count_next = nonzero_count + ecm_pkg::COUNT_W'(1);
    end else if (do_write && prior_val != '0 && wr_val == '0) begin
      nonzero_count_next = nonzero_count - ecm_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero_count  <= '0;
      new_edge_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (commit) begin
        nonzero_count  <= nonzero_count_next;
        new_edge_count <= new_edge_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      success        <= ok;
      out_of_range   <= reject_q;
      old_value      <= prior_val;
      is_rare        <= rare;
      covered_slots  <= nonzero_count_next;
      new_edge_total <= new_edge_count_next;
    end
  end

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during clearing sweep");

  a_reject_clean : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (!success && old_value == '0 && !is_rare))
    else $error("rejected request reports a write or a value");

  a_new_edge_count : assert property (@(posedge clk) disable iff (rst)
    (commit && ok && kind == ecm_pkg::REQ_RECORD)
      |=> (new_edge_count == $past(new_edge_count) + ecm_pkg::TOTAL_W'(1)))
    else $error("new edge not counted");

  a_no_write_when_rejected : assert property (@(posedge clk) disable iff (rst)
    (state == ecm_pkg::ST_MODIFY && reject_q) |-> !do_write)
    else $error("write to a rejected index");

endmodule
`default_nettype wire
